// ----- rtl/core/gpbf_pkg.sv -----
// shared types and constants of the glyph path bezier flattener
`default_nettype none

package gpbf_pkg;

  localparam int CW           = 32;               // coordinate width
  localparam int MAX_SEGMENTS = 64;
  localparam int SEG_W        = 7;
  localparam int DIV_STEPS    = 17;               // bits of the 65536 dividend
  localparam int IN_DATA_W    = 6 * CW;
  localparam int OUT_DATA_W   = 2 * CW;

  localparam logic [2:0] ACT_MOVE    = 3'd0;
  localparam logic [2:0] ACT_LINE    = 3'd1;
  localparam logic [2:0] ACT_QUAD    = 3'd2;
  localparam logic [2:0] ACT_CUBIC   = 3'd3;
  localparam logic [2:0] ACT_OFFSET  = 3'd4;
  localparam logic [2:0] ACT_ADVANCE = 3'd5;

  localparam logic REG_SEGMENTS = 1'b0;
  localparam logic REG_SCALE    = 1'b1;

  localparam logic [SEG_W-1:0] SEG_RESET   = 7'd8;
  localparam logic [CW-1:0]    SCALE_RESET = 32'h0001_0000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_STEP, ST_WQ, ST_WC, ST_TERM, ST_SCALE, ST_OUT
  } state_t;

  // multiplier operand selection
  typedef enum logic [3:0] {
    MOP_NONE, MOP_UU, MOP_TT, MOP_U2T, MOP_UUU, MOP_UU3T, MOP_TT3U, MOP_TTT,
    MOP_CH, MOP_CL, MOP_SH, MOP_SL
  } mop_t;

  // product writeback
  typedef enum logic [3:0] {
    WOP_NONE, WOP_UU, WOP_TT, WOP_WQ, WOP_WC, WOP_HI, WOP_ACC, WOP_MAG, WOP_OUT
  } wop_t;

  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       div_first;
    logic       step;
    mop_t       mop;
    logic [1:0] mk;
    logic       max;
    wop_t       wop;
    logic [1:0] wk;
    logic       wax;
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/gpbf_ctrl.sv -----
// controller state machine: sequences division, weights, terms and scaling
`default_nettype none

module gpbf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic [2:0]    in_action,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  wire gpbf_pkg::sts_t sts,
  output gpbf_pkg::cmd_t     cmd
);
  import gpbf_pkg::*;

  state_t     state_r, state_nxt;
  logic [4:0] pc_r, pc_nxt;
  logic       cubic_r, cubic_nxt;
  logic [4:0] q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= '0;
      cubic_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      cubic_r <= cubic_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r + 5'd1;
    cubic_nxt     = cubic_r;
    in_tready     = 1'b0;
    out_tvalid    = 1'b0;
    cmd.load      = 1'b0;
    cmd.div_step  = 1'b0;
    cmd.div_first = 1'b0;
    cmd.step      = 1'b0;
    cmd.mop       = MOP_NONE;
    cmd.mk        = 2'd0;
    cmd.max       = 1'b0;
    cmd.wop       = WOP_NONE;
    cmd.wk        = 2'd0;
    cmd.wax       = 1'b0;
    q             = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        pc_nxt    = '0;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          case (in_action)
            ACT_MOVE, ACT_LINE: state_nxt = ST_SCALE;
            ACT_QUAD, ACT_CUBIC: begin
              state_nxt = ST_DIV;
              cubic_nxt = (in_action == ACT_CUBIC);
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (pc_r == '0);
        if (pc_r == 5'(DIV_STEPS - 1)) begin
          state_nxt = ST_STEP;
          pc_nxt    = '0;
        end
      end
      ST_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = cubic_r ? ST_WC : ST_WQ;
        pc_nxt    = '0;
      end
      ST_WQ: begin
        case (pc_r)
          5'd0: cmd.mop = MOP_UU;
          5'd1: begin
            cmd.mop = MOP_TT;
            cmd.wop = WOP_UU;
          end
          5'd2: begin
            cmd.mop = MOP_U2T;
            cmd.wop = WOP_TT;
          end
          default: begin
            cmd.wop   = WOP_WQ;
            state_nxt = ST_TERM;
            pc_nxt    = '0;
          end
        endcase
      end
      ST_WC: begin
        cmd.wk = 2'(pc_r - 5'd3);
        case (pc_r)
          5'd0: cmd.mop = MOP_UU;
          5'd1: begin
            cmd.mop = MOP_TT;
            cmd.wop = WOP_UU;
          end
          5'd2: begin
            cmd.mop = MOP_UUU;
            cmd.wop = WOP_TT;
          end
          5'd3: begin
            cmd.mop = MOP_UU3T;
            cmd.wop = WOP_WC;
          end
          5'd4: begin
            cmd.mop = MOP_TT3U;
            cmd.wop = WOP_WC;
          end
          5'd5: begin
            cmd.mop = MOP_TTT;
            cmd.wop = WOP_WC;
          end
          default: begin
            cmd.wop   = WOP_WC;
            state_nxt = ST_TERM;
            pc_nxt    = '0;
          end
        endcase
      end
      ST_TERM: begin
        // two products per term: high and low half of the weight
        if (!pc_r[4]) begin
          cmd.mop = pc_r[0] ? MOP_CL : MOP_CH;
          cmd.mk  = pc_r[3:2];
          cmd.max = pc_r[1];
        end
        if (pc_r != '0) begin
          q       = pc_r - 5'd1;
          cmd.wop = q[0] ? WOP_ACC : WOP_HI;
          cmd.wk  = q[3:2];
          cmd.wax = q[1];
        end
        if (pc_r[4]) begin
          state_nxt = ST_SCALE;
          pc_nxt    = '0;
        end
      end
      ST_SCALE: begin
        if (pc_r == '0) begin
          cmd.wop = WOP_MAG;
        end
        if (pc_r >= 5'd1 && pc_r <= 5'd4) begin
          q       = pc_r - 5'd1;
          cmd.mop = q[0] ? MOP_SL : MOP_SH;
          cmd.max = q[1];
        end
        if (pc_r >= 5'd2) begin
          q       = pc_r - 5'd2;
          cmd.wop = q[0] ? WOP_OUT : WOP_HI;
          cmd.wax = q[1];
        end
        if (pc_r == 5'd5) begin
          state_nxt = ST_OUT;
          pc_nxt    = '0;
        end
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        pc_nxt     = '0;
        if (out_tready) begin
          state_nxt = sts.last ? ST_IDLE : ST_STEP;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/gpbf_dp.sv -----
// datapath: path state, divider, shared multiplier, accumulators, output register
`default_nettype none

module gpbf_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire gpbf_pkg::cmd_t                 cmd,
  output gpbf_pkg::sts_t                      sts,
  input  wire logic [2:0]                     in_action,
  input  wire logic [gpbf_pkg::IN_DATA_W-1:0] in_data,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [gpbf_pkg::CW-1:0]        cfg_data,
  output logic [gpbf_pkg::OUT_DATA_W-1:0]     out_data,
  output logic                                out_start,
  output logic                                out_last
);
  import gpbf_pkg::*;

  function automatic logic signed [CW-1:0] sat32_f(input logic signed [34:0] v);
    if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
      return v[31:0];
    end
    return v[34] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  // configuration and path state
  logic [SEG_W-1:0]     seg_r;
  logic [CW-1:0]        scale_r;
  logic signed [CW-1:0] pen_r [2];
  logic signed [CW-1:0] off_r [2];
  logic signed [CW-1:0] adv_r [2];

  // per command working registers
  logic signed [CW-1:0] c_r [2][4];
  logic [SEG_W-1:0]     n_r;
  logic [16:0]          dq_r;
  logic [SEG_W-1:0]     dr_r;
  logic [SEG_W-1:0]     ra_r;
  logic [SEG_W-1:0]     i_r;
  logic [16:0]          t_r;
  logic [32:0]          uu_r, tt_r;
  logic [32:0]          w_r [4];
  logic signed [52:0]   p_r, hi_r;
  logic signed [34:0]   acc_r [2];
  logic [33:0]          mag_r [2];
  logic                 neg_r [2];
  logic signed [CW-1:0] vout_r [2];
  logic                 start_r, last_r;

  logic signed [CW-1:0] e_w [2];
  logic signed [CW-1:0] a_w [2];
  logic signed [CW-1:0] b_w [2];
  logic [16:0]          u_w;
  logic signed [34:0]   mul_a;
  logic [17:0]          mul_b;
  logic signed [53:0]   prod;
  logic [SEG_W-1:0]     n_eff;
  logic [SEG_W:0]       div_r2, st_sum;
  logic [SEG_W-1:0]     div_rin;
  logic                 div_ge, st_ge;
  logic signed [69:0]   tsum;
  logic signed [33:0]   s_w [2];
  logic [52:0]          m_sum;
  logic signed [CW-1:0] out_sat;
  logic signed [32:0]   adv_sum [2];

  assign e_w[0] = in_data[31:0];
  assign e_w[1] = in_data[63:32];
  assign a_w[0] = in_data[95:64];
  assign a_w[1] = in_data[127:96];
  assign b_w[0] = in_data[159:128];
  assign b_w[1] = in_data[191:160];

  assign u_w = 17'h1_0000 - t_r;

  always_comb begin
    if (seg_r == '0) begin
      n_eff = 7'd1;
    end else if (seg_r > 7'(MAX_SEGMENTS)) begin
      n_eff = 7'(MAX_SEGMENTS);
    end else begin
      n_eff = seg_r;
    end
  end

  // restoring divider step for 65536 / n, one quotient bit a cycle
  assign div_rin = cmd.div_first ? '0 : dr_r;
  assign div_r2  = {div_rin, cmd.div_first};
  assign div_ge  = div_r2 >= {1'b0, n_r};

  // parameter step: t += q, remainder carried
  assign st_sum = {1'b0, ra_r} + {1'b0, dq_r[0] & 1'b0, dr_r[SEG_W-2:0]};
  assign st_ge  = st_sum >= {1'b0, n_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mop)
      MOP_UU: begin
        mul_a = 35'(u_w);
        mul_b = 18'(u_w);
      end
      MOP_TT: begin
        mul_a = 35'(t_r);
        mul_b = 18'(t_r);
      end
      MOP_U2T: begin
        mul_a = 35'(u_w);
        mul_b = {t_r, 1'b0};
      end
      MOP_UUU: begin
        mul_a = 35'(uu_r);
        mul_b = 18'(u_w);
      end
      MOP_UU3T: begin
        mul_a = 35'(uu_r);
        mul_b = {t_r, 1'b0} + 18'(t_r);
      end
      MOP_TT3U: begin
        mul_a = 35'(tt_r);
        mul_b = {u_w, 1'b0} + 18'(u_w);
      end
      MOP_TTT: begin
        mul_a = 35'(tt_r);
        mul_b = 18'(t_r);
      end
      MOP_CH: begin
        mul_a = 35'(c_r[cmd.max][cmd.mk]);
        mul_b = 18'(w_r[cmd.mk][32:16]);
      end
      MOP_CL: begin
        mul_a = 35'(c_r[cmd.max][cmd.mk]);
        mul_b = 18'(w_r[cmd.mk][15:0]);
      end
      MOP_SH: begin
        mul_a = {1'b0, mag_r[cmd.max]};
        mul_b = 18'(scale_r[31:16]);
      end
      MOP_SL: begin
        mul_a = {1'b0, mag_r[cmd.max]};
        mul_b = 18'(scale_r[15:0]);
      end
      default: ;
    endcase
  end

  assign prod = mul_a * $signed({1'b0, mul_b});

  // floored term: (hi * 2^16 + lo) / 2^32
  assign tsum = (70'(hi_r) <<< 16) + 70'(p_r);

  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      s_w[ax] = 34'(sat32_f(acc_r[ax])) + 34'(off_r[ax]) + 34'(adv_r[ax]);
      adv_sum[ax] = 33'(adv_r[ax]) + 33'(e_w[ax]);
    end
  end

  // magnitude times scale, truncated toward zero, then saturated
  assign m_sum = hi_r[52:0] + {16'd0, p_r[52:16]};

  always_comb begin
    if (neg_r[cmd.wax]) begin
      out_sat = (m_sum > 53'h8000_0000) ? 32'sh8000_0000 : 32'(-m_sum);
    end else begin
      out_sat = (m_sum > 53'h7fff_ffff) ? 32'sh7fff_ffff : 32'(m_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r   <= SEG_RESET;
      scale_r <= SCALE_RESET;
      for (int ax = 0; ax < 2; ax++) begin
        pen_r[ax] <= '0;
        off_r[ax] <= '0;
        adv_r[ax] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SEGMENTS: seg_r   <= cfg_data[SEG_W-1:0];
          REG_SCALE:    scale_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        case (in_action)
          ACT_MOVE, ACT_LINE, ACT_QUAD, ACT_CUBIC: begin
            pen_r[0] <= e_w[0];
            pen_r[1] <= e_w[1];
          end
          ACT_OFFSET: begin
            off_r[0] <= e_w[0];
            off_r[1] <= e_w[1];
          end
          ACT_ADVANCE: begin
            adv_r[0] <= sat32_f(35'(adv_sum[0]));
            adv_r[1] <= sat32_f(35'(adv_sum[1]));
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r <= prod[52:0];
    if (cmd.load) begin
      start_r <= (in_action == ACT_MOVE);
      last_r  <= 1'b1;
      n_r     <= n_eff;
      t_r     <= '0;
      ra_r    <= '0;
      i_r     <= '0;
      for (int ax = 0; ax < 2; ax++) begin
        acc_r[ax]   <= 35'(e_w[ax]);
        c_r[ax][0]  <= pen_r[ax];
        c_r[ax][1]  <= a_w[ax];
        c_r[ax][2]  <= (in_action == ACT_CUBIC) ? b_w[ax] : e_w[ax];
        c_r[ax][3]  <= e_w[ax];
      end
    end
    if (cmd.div_step) begin
      dq_r <= {dq_r[15:0], div_ge};
      dr_r <= div_ge ? SEG_W'(div_r2 - {1'b0, n_r}) : SEG_W'(div_r2);
    end
    if (cmd.step) begin
      t_r      <= t_r + dq_r + 17'(st_ge);
      ra_r     <= st_ge ? SEG_W'(st_sum - {1'b0, n_r}) : SEG_W'(st_sum);
      i_r      <= i_r + 7'd1;
      last_r   <= (i_r + 7'd1) == n_r;
      acc_r[0] <= '0;
      acc_r[1] <= '0;
    end
    case (cmd.wop)
      WOP_UU: uu_r <= p_r[32:0];
      WOP_TT: tt_r <= p_r[32:0];
      WOP_WQ: begin
        w_r[0] <= uu_r;
        w_r[1] <= p_r[32:0];
        w_r[2] <= tt_r;
        w_r[3] <= '0;
      end
      WOP_WC:  w_r[cmd.wk] <= p_r[48:16];
      WOP_HI:  hi_r <= p_r;
      WOP_ACC: acc_r[cmd.wax] <= acc_r[cmd.wax] + $signed(tsum[66:32]);
      WOP_MAG: begin
        for (int ax = 0; ax < 2; ax++) begin
          neg_r[ax] <= s_w[ax][33];
          mag_r[ax] <= s_w[ax][33] ? 34'(-s_w[ax]) : 34'(s_w[ax]);
        end
      end
      WOP_OUT: vout_r[cmd.wax] <= out_sat;
      default: ;
    endcase
  end

  assign out_data  = {vout_r[1], vout_r[0]};
  assign out_start = start_r;
  assign out_last  = last_r;
  assign sts.last  = last_r;

endmodule

`default_nettype wire

// ----- rtl/core/glyph_path_bezier_flattener.sv -----
// top level of the glyph path bezier flattener
// usage:
// - in_* takes one path command per item: in_tuser is the action (move, line,
//   quadratic, cubic, set offset, add advance), in_tdata the six coordinates
// - out_* gives the scaled vertices; out_tlast marks the final vertex of a
//   command and out_tuser marks the vertex of a move
// - cfg_* writes the segment count (index 0) and the Q16.16 scale (index 1)
// - one command is worked on at a time; in_tready is high only while idle
// - move or line: out_tvalid rises after the end point is scaled
// - offset and advance: no vertex
// - curve: a 65536/n division, then per vertex a step, the quadratic or
//   cubic weights, the terms and the scaling, for n segments
// - every weight, term and scale product goes through the single shared
//   35x18 multiplier
// - a stall on out_tready holds the vertex and the whole sequence
// - reset clears the pen, offset and advance and restores the registers
`default_nettype none

module glyph_path_bezier_flattener (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y from bit 0 up
  input  wire logic [191:0]  in_tdata,
  // action
  input  wire logic [2:0]    in_tuser,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // vertex_x, vertex_y from bit 0 up
  output logic [63:0]        out_tdata,
  // starts_outline
  output logic [0:0]         out_tuser,
  output logic               out_tlast,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [31:0]   cfg_data
);
  import gpbf_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic start_w;

  // sequencer: one command at a time
  gpbf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_action  (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // arithmetic and state
  gpbf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_action (in_tuser),
    .in_data   (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_tdata),
    .out_start (start_w),
    .out_last  (out_tlast)
  );

  assign out_tuser = start_w;

endmodule

`default_nettype wire

// ----- rtl/core/gpbf_checker.sv -----
// port level checks of the flattener, bound to the top level
`default_nettype none

module gpbf_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [2:0]   in_tuser,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [63:0]  out_tdata,
  input wire logic         out_tlast
);
  import gpbf_pkg::*;

  // one command at a time: never ready for input while a vertex waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a vertex is shown");

  // no vertex in the cycle after an item is taken
  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid)
    else $error("vertex right after accept");

  // a curve keeps the input closed for the next cycle
  a_curve_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == ACT_QUAD || in_tuser == ACT_CUBIC)
    |=> !in_tready)
    else $error("input open during curve");

  // after the final vertex is taken no vertex follows at once
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("vertex right after final vertex");

  // a stalled vertex holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled vertex changed");

endmodule

bind glyph_path_bezier_flattener gpbf_checker u_gpbf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
